### rtl/core/rde_pkg.sv
// Package of the radix digit extractor: shared constants, the control
// record that travels down the pipeline, and the radix clamp function.
// Depends on nothing; every module of the block imports it.
package rde_pkg;

    localparam int DEFAULT_VALUE_WIDTH = 32;
    localparam int CHUNK_BITS          = 8;

    localparam logic [5:0] RADIX_RESET = 6'd10;
    localparam logic [5:0] RADIX_MIN   = 6'd2;
    localparam logic [5:0] RADIX_MAX   = 6'd36;

    typedef struct packed {
        logic       valid;
        logic       zero;
        logic [5:0] pos;
        logic [5:0] radix;
    } t_rde_ctl;

    function automatic logic [5:0] clamp_radix(input logic [5:0] r);
        logic [5:0] res;
        res = r;
        if (r < RADIX_MIN) begin
            res = RADIX_MIN;
        end else if (r > RADIX_MAX) begin
            res = RADIX_MAX;
        end
        return res;
    endfunction

endpackage

### rtl/core/rde_front.sv
// Input stage: sign-extends the value, forms its magnitude and registers it
// together with the position and the clamped radix.
// Depends on rde_pkg.
module rde_front #(
    parameter int VALUE_WIDTH = 32
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_en,
    input  logic                   i_valid,
    input  logic [31:0]            i_value,
    input  logic [5:0]             i_pos,
    input  logic [5:0]             i_radix,
    output rde_pkg::t_rde_ctl      o_ctl,
    output logic [VALUE_WIDTH-1:0] o_mag
);
    import rde_pkg::*;

    logic signed [31:0]     s_value;
    logic [VALUE_WIDTH-1:0] x;
    logic [VALUE_WIDTH-1:0] n_mag;
    t_rde_ctl               r_ctl;
    logic [VALUE_WIDTH-1:0] r_mag;

    assign s_value = i_value;
    assign x       = VALUE_WIDTH'(s_value);
    assign n_mag   = x[VALUE_WIDTH-1] ? (~x + 1'b1) : x;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl.valid <= 1'b0;
        end else if (i_en) begin
            r_ctl.valid <= i_valid;
        end
        if (i_en) begin
            r_ctl.zero  <= (n_mag == '0);
            r_ctl.pos   <= i_pos;
            r_ctl.radix <= clamp_radix(i_radix);
            r_mag       <= n_mag;
        end
    end

    assign o_ctl = r_ctl;
    assign o_mag = r_mag;

endmodule

### rtl/core/rde_div_stage.sv
// One pipeline stage of the repeated division: a chunk of long-division
// bit steps of one quotient, plus the digit capture at the end of a division.
// Depends on rde_pkg.
module rde_div_stage #(
    parameter int VALUE_WIDTH = 32,
    parameter int COUNT_WIDTH = 6,
    parameter int FIRST_BIT   = 31,
    parameter int NUM_BITS    = 8,
    parameter int DIV_IDX     = 0,
    parameter bit IS_START    = 1'b1,
    parameter bit IS_END      = 1'b0
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_en,
    input  rde_pkg::t_rde_ctl                 i_ctl,
    input  logic [VALUE_WIDTH-1:0]            i_t,
    input  logic [VALUE_WIDTH-1:0]            i_q,
    input  logic [5:0]                        i_rem,
    input  logic [VALUE_WIDTH-1:0][5:0]       i_digits,
    input  logic [COUNT_WIDTH-1:0]            i_count,
    output rde_pkg::t_rde_ctl                 o_ctl,
    output logic [VALUE_WIDTH-1:0]            o_t,
    output logic [VALUE_WIDTH-1:0]            o_q,
    output logic [5:0]                        o_rem,
    output logic [VALUE_WIDTH-1:0][5:0]       o_digits,
    output logic [COUNT_WIDTH-1:0]            o_count
);
    import rde_pkg::*;

    logic [VALUE_WIDTH-1:0]      n_t;
    logic [VALUE_WIDTH-1:0]      n_q;
    logic [5:0]                  n_rem;
    logic [VALUE_WIDTH-1:0][5:0] n_digits;
    logic [COUNT_WIDTH-1:0]      n_count;
    logic [6:0]                  rem2;
    logic [VALUE_WIDTH-1:0]      q;
    logic [5:0]                  rem;

    t_rde_ctl                    r_ctl;
    logic [VALUE_WIDTH-1:0]      r_t;
    logic [VALUE_WIDTH-1:0]      r_q;
    logic [5:0]                  r_rem;
    logic [VALUE_WIDTH-1:0][5:0] r_digits;
    logic [COUNT_WIDTH-1:0]      r_count;

    always_comb begin
        q    = IS_START ? '0 : i_q;
        rem  = IS_START ? 6'd0 : i_rem;
        rem2 = '0;
        for (int j = 0; j < NUM_BITS; j++) begin
            rem2 = {rem, i_t[FIRST_BIT - j]};
            if (rem2 >= {1'b0, i_ctl.radix}) begin
                q[FIRST_BIT - j] = 1'b1;
                rem2             = rem2 - {1'b0, i_ctl.radix};
            end
            rem = rem2[5:0];
        end
        n_q      = q;
        n_rem    = rem;
        n_digits = i_digits;
        n_count  = i_count;
        n_t      = i_t;
        if (IS_END) begin
            n_digits[DIV_IDX] = rem;
            n_t               = q;
            if (i_t != '0) begin
                n_count = i_count + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl.valid <= 1'b0;
        end else if (i_en) begin
            r_ctl.valid <= i_ctl.valid;
        end
        if (i_en) begin
            r_ctl.zero  <= i_ctl.zero;
            r_ctl.pos   <= i_ctl.pos;
            r_ctl.radix <= i_ctl.radix;
            r_t         <= n_t;
            r_q         <= n_q;
            r_rem       <= n_rem;
            r_digits    <= n_digits;
            r_count     <= n_count;
        end
    end

    assign o_ctl    = r_ctl;
    assign o_t      = r_t;
    assign o_q      = r_q;
    assign o_rem    = r_rem;
    assign o_digits = r_digits;
    assign o_count  = r_count;

endmodule

### rtl/core/rde_select.sv
// Output stage: checks the position against the digit count, picks the
// digit and registers the result beat.
// Depends on rde_pkg.
module rde_select #(
    parameter int VALUE_WIDTH = 32,
    parameter int COUNT_WIDTH = 6
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_en,
    input  rde_pkg::t_rde_ctl           i_ctl,
    input  logic [VALUE_WIDTH-1:0][5:0] i_digits,
    input  logic [COUNT_WIDTH-1:0]      i_count,
    output logic                        o_valid,
    output logic [5:0]                  o_digit,
    output logic [5:0]                  o_count,
    output logic                        o_status
);
    import rde_pkg::*;

    localparam int IDX_WIDTH = $clog2(VALUE_WIDTH);

    logic [6:0]           cnt7;
    logic [6:0]           diff;
    logic [IDX_WIDTH-1:0] idx;
    logic                 n_status;
    logic [5:0]           n_digit;
    logic [5:0]           n_count;
    logic                 r_valid;
    logic [5:0]           r_digit;
    logic [5:0]           r_count;
    logic                 r_status;

    always_comb begin
        cnt7     = 7'(i_count);
        diff     = cnt7 - 7'(i_ctl.pos);
        idx      = diff[IDX_WIDTH-1:0];
        n_status = (i_ctl.pos == 6'd0) || (7'(i_ctl.pos) > cnt7);
        n_digit  = n_status ? 6'd0 : i_digits[idx];
        n_count  = (cnt7 > 7'd63) ? 6'd63 : cnt7[5:0];
        if (i_ctl.zero) begin
            n_status = 1'b0;
            n_digit  = 6'd0;
            n_count  = 6'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_ctl.valid;
        end
        if (i_en) begin
            r_digit  <= n_digit;
            r_count  <= n_count;
            r_status <= n_status;
        end
    end

    assign o_valid  = r_valid;
    assign o_digit  = r_digit;
    assign o_count  = r_count;
    assign o_status = r_status;

endmodule

### rtl/core/radix_digit_extractor.sv
// Channel   | Dir | Handshake                  | Payload
// s_axis    | in  | s_axis_tvalid/tready       | tdata[31:0] value, [37:32] digit_index
// m_axis    | out | m_axis_tvalid/tready       | tdata[5:0] digit, [11:6] count, [12] status
// cfg       | in  | i_cfg_valid/o_cfg_ready    | i_cfg_data[5:0] radix
// One beat is accepted per cycle while the output is not stalled; the pipeline does one long
// division per digit, with at most 8 bit steps per stage.
// The whole pipeline holds when the output beat is stalled; nothing is lost or repeated.
// Reset is synchronous and active low; it clears the valid bits and sets the radix to 10.
// Depends on rde_pkg, rde_front, rde_div_stage and rde_select.
module radix_digit_extractor #(
    parameter int VALUE_WIDTH = rde_pkg::DEFAULT_VALUE_WIDTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,  // value[31:0], digit_index[37:32], zero fill
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,  // digit[5:0], digit_count[11:6], status[12], zero fill
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [5:0]  i_cfg_data
);
    import rde_pkg::*;

    localparam int DIV_STAGES  = (VALUE_WIDTH + CHUNK_BITS - 1) / CHUNK_BITS;
    localparam int NUM_STAGES  = VALUE_WIDTH * DIV_STAGES;
    localparam int COUNT_WIDTH = $clog2(VALUE_WIDTH + 1);

    logic [5:0] r_radix;
    logic       en;
    logic [5:0] out_digit;
    logic [5:0] out_count;
    logic       out_status;

    t_rde_ctl                    ctl    [NUM_STAGES+1];
    logic [VALUE_WIDTH-1:0]      t_v    [NUM_STAGES+1];
    logic [VALUE_WIDTH-1:0]      q_v    [NUM_STAGES+1];
    logic [5:0]                  rem_v  [NUM_STAGES+1];
    logic [VALUE_WIDTH-1:0][5:0] dig_v  [NUM_STAGES+1];
    logic [COUNT_WIDTH-1:0]      cnt_v  [NUM_STAGES+1];

    assign o_cfg_ready   = 1'b1;
    assign en            = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radix <= RADIX_RESET;
        end else if (i_cfg_valid) begin
            r_radix <= i_cfg_data;
        end
    end

    rde_front #(.VALUE_WIDTH(VALUE_WIDTH)) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (s_axis_tvalid),
        .i_value (s_axis_tdata[31:0]),
        .i_pos   (s_axis_tdata[37:32]),
        .i_radix (r_radix),
        .o_ctl   (ctl[0]),
        .o_mag   (t_v[0])
    );

    assign q_v[0]   = '0;
    assign rem_v[0] = '0;
    assign dig_v[0] = '0;
    assign cnt_v[0] = '0;

    for (genvar s = 0; s < NUM_STAGES; s++) begin : g_stage
        localparam int DV = s / DIV_STAGES;
        localparam int CK = s % DIV_STAGES;
        localparam int FB = VALUE_WIDTH - 1 - CK * CHUNK_BITS;
        localparam int NB = (FB + 1 < CHUNK_BITS) ? FB + 1 : CHUNK_BITS;
        rde_div_stage #(
            .VALUE_WIDTH (VALUE_WIDTH),
            .COUNT_WIDTH (COUNT_WIDTH),
            .FIRST_BIT   (FB),
            .NUM_BITS    (NB),
            .DIV_IDX     (DV),
            .IS_START    (CK == 0),
            .IS_END      (CK == DIV_STAGES - 1)
        ) u_div (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_en     (en),
            .i_ctl    (ctl[s]),
            .i_t      (t_v[s]),
            .i_q      (q_v[s]),
            .i_rem    (rem_v[s]),
            .i_digits (dig_v[s]),
            .i_count  (cnt_v[s]),
            .o_ctl    (ctl[s+1]),
            .o_t      (t_v[s+1]),
            .o_q      (q_v[s+1]),
            .o_rem    (rem_v[s+1]),
            .o_digits (dig_v[s+1]),
            .o_count  (cnt_v[s+1])
        );
    end

    rde_select #(
        .VALUE_WIDTH (VALUE_WIDTH),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_select (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (en),
        .i_ctl    (ctl[NUM_STAGES]),
        .i_digits (dig_v[NUM_STAGES]),
        .i_count  (cnt_v[NUM_STAGES]),
        .o_valid  (m_axis_tvalid),
        .o_digit  (out_digit),
        .o_count  (out_count),
        .o_status (out_status)
    );

    assign m_axis_tdata = {3'b000, out_status, out_count, out_digit};

    ap_error_digit_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && out_status) |-> (out_digit == 6'd0))
        else $error("Flagged position carries a non-zero digit.");

    ap_count_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (out_count != 6'd0))
        else $error("Result beat carries a digit count of zero.");

    ap_digit_below_radix: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !out_status) |-> (out_digit < RADIX_MAX))
        else $error("Selected digit is not below the largest radix.");

    ap_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !en |=> $stable(ctl[NUM_STAGES]))
        else $error("Pipeline advanced during an output stall.");

endmodule
